>>> rtl/mtc_pkg.sv
// mtc_pkg: types, constants and code table lookups for the morse text codec
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

	localparam int MTC_MAX_SYMBOLS = 7;
	localparam int MTC_QUEUE_DEPTH = 4;
	localparam int ENTRY_COUNT     = 53;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_DASH = 8'h2D;

	localparam logic [7:0] RESET_DOT  = 8'h2E;
	localparam logic [7:0] RESET_DASH = 8'h2D;
	localparam logic [7:0] RESET_SEP  = 8'h2F;

	typedef enum logic [1:0] {
		CFG_DIRECTION = 2'd0,
		CFG_DOT       = 2'd1,
		CFG_DASH      = 2'd2,
		CFG_SEPARATOR = 2'd3
	} cfg_index_t;

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} direction_t;

	typedef enum logic {
		JOB_ENC = 1'b0,
		JOB_DEC = 1'b1
	} job_kind_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		direction_t direction;
		logic [7:0] dot_char;
		logic [7:0] dash_char;
		logic [7:0] separator_char;
	} cfg_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [2:0] len;
		logic [6:0] pat;
		logic [7:0] glyph;
	} job_t;

	// pattern bit i set means symbol i is a dash
	typedef struct packed {
		logic [7:0] glyph;
		logic [2:0] len;
		logic [6:0] pat;
	} morse_entry_t;

	typedef struct packed {
		logic       found;
		logic [2:0] len;
		logic [6:0] pat;
	} enc_result_t;

	typedef struct packed {
		logic       found;
		logic [7:0] glyph;
	} dec_result_t;

	localparam morse_entry_t MORSE_TABLE [0:ENTRY_COUNT-1] = '{
		'{8'h41, 3'd2, 7'b0000010}, '{8'h42, 3'd4, 7'b0000001},
		'{8'h43, 3'd4, 7'b0000101}, '{8'h44, 3'd3, 7'b0000001},
		'{8'h45, 3'd1, 7'b0000000}, '{8'h46, 3'd4, 7'b0000100},
		'{8'h47, 3'd3, 7'b0000011}, '{8'h48, 3'd4, 7'b0000000},
		'{8'h49, 3'd2, 7'b0000000}, '{8'h4A, 3'd4, 7'b0001110},
		'{8'h4B, 3'd3, 7'b0000101}, '{8'h4C, 3'd4, 7'b0000010},
		'{8'h4D, 3'd2, 7'b0000011}, '{8'h4E, 3'd2, 7'b0000001},
		'{8'h4F, 3'd3, 7'b0000111}, '{8'h50, 3'd4, 7'b0000110},
		'{8'h51, 3'd4, 7'b0001011}, '{8'h52, 3'd3, 7'b0000010},
		'{8'h53, 3'd3, 7'b0000000}, '{8'h54, 3'd1, 7'b0000001},
		'{8'h55, 3'd3, 7'b0000100}, '{8'h56, 3'd4, 7'b0001000},
		'{8'h57, 3'd3, 7'b0000110}, '{8'h58, 3'd4, 7'b0001001},
		'{8'h59, 3'd4, 7'b0001101}, '{8'h5A, 3'd4, 7'b0000011},
		'{8'h31, 3'd5, 7'b0011110}, '{8'h32, 3'd5, 7'b0011100},
		'{8'h33, 3'd5, 7'b0011000}, '{8'h34, 3'd5, 7'b0010000},
		'{8'h35, 3'd5, 7'b0000000}, '{8'h36, 3'd5, 7'b0000001},
		'{8'h37, 3'd5, 7'b0000011}, '{8'h38, 3'd5, 7'b0000111},
		'{8'h39, 3'd5, 7'b0001111}, '{8'h30, 3'd5, 7'b0011111},
		'{8'h2E, 3'd6, 7'b0101010}, '{8'h3A, 3'd6, 7'b0000111},
		'{8'h2C, 3'd6, 7'b0110011}, '{8'h3B, 3'd6, 7'b0010101},
		'{8'h3F, 3'd6, 7'b0001100}, '{8'h3D, 3'd5, 7'b0010001},
		'{8'h27, 3'd6, 7'b0011110}, '{8'h2F, 3'd5, 7'b0001001},
		'{8'h21, 3'd6, 7'b0110101}, '{8'h2D, 3'd6, 7'b0100001},
		'{8'h5F, 3'd6, 7'b0101100}, '{8'h22, 3'd6, 7'b0010010},
		'{8'h28, 3'd5, 7'b0001101}, '{8'h29, 3'd6, 7'b0101101},
		'{8'h24, 3'd7, 7'b1001000}, '{8'h26, 3'd5, 7'b0000010},
		'{8'h40, 3'd6, 7'b0010110}
	};

	// first matching entry wins
	function automatic enc_result_t enc_lookup(logic [7:0] key);
		enc_result_t r;
		r = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if (MORSE_TABLE[i].glyph == key) begin
				r.found = 1'b1;
				r.len   = MORSE_TABLE[i].len;
				r.pat   = MORSE_TABLE[i].pat;
			end
		end
		return r;
	endfunction

	function automatic dec_result_t dec_lookup(logic [3:0] len, logic [7:0] pat);
		dec_result_t r;
		r = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if ({1'b0, MORSE_TABLE[i].len} == len && {1'b0, MORSE_TABLE[i].pat} == pat) begin
				r.found = 1'b1;
				r.glyph = MORSE_TABLE[i].glyph;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/mtc_front.sv
// mtc_front: accepts text characters, looks up codes and gathers decode tokens
// depends on mtc_pkg; pushes jobs into mtc_queue
`timescale 1ns / 1ps
`default_nettype none

module mtc_front
	import mtc_pkg::*;
#(
	parameter int MAX_SYMBOLS = MTC_MAX_SYMBOLS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_item,
	input  wire logic     q_full,
	output logic          push,
	output job_t          push_job
);

	localparam int PAT_W = MAX_SYMBOLS;
	localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);

	logic [PAT_W-1:0] pat_q, pat_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             bad_q, bad_n;

	logic             accept;
	logic [7:0]       key;
	enc_result_t      enc;
	dec_result_t      dec;
	logic             flush;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		key = in_item.char_in;
		if (in_item.char_in inside {[8'h61:8'h7A]}) begin
			key = in_item.char_in - 8'd32;
		end
		enc = enc_lookup(key);

		pat_n = pat_q;
		len_n = len_q;
		bad_n = bad_q;
		flush = 1'b0;
		if (in_item.char_in == cfg.separator_char) begin
			flush = 1'b1;
		end else begin
			if (in_item.char_in == CHAR_DOT || in_item.char_in == CHAR_DASH) begin
				if (len_q < LEN_W'(MAX_SYMBOLS)) begin
					if (in_item.char_in == CHAR_DASH) begin
						pat_n = pat_q | (PAT_W'(1) << len_q);
					end
					len_n = len_q + LEN_W'(1);
				end else begin
					bad_n = 1'b1;
				end
			end else begin
				bad_n = 1'b1;
			end
			flush = in_item.end_of_text;
		end
		dec = dec_lookup(4'(len_n), 8'(pat_n));

		push_job       = '0;
		push_job.len   = enc.len;
		push_job.pat   = enc.pat;
		push_job.glyph = dec.glyph;
		if (cfg.direction == DIR_ENCODE) begin
			push_job.kind = JOB_ENC;
			push          = accept && enc.found;
		end else begin
			push_job.kind = JOB_DEC;
			push          = accept && flush && !bad_n && len_n != '0 && dec.found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
			bad_q <= 1'b0;
		end else if (accept && cfg.direction == DIR_DECODE) begin
			if (flush) begin
				pat_q <= '0;
				len_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pat_q <= pat_n;
				len_q <= len_n;
				bad_q <= bad_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/mtc_queue.sv
// mtc_queue: short job queue between front and back of the morse text codec
// depends on mtc_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module mtc_queue
	import mtc_pkg::*;
#(
	parameter int DEPTH = MTC_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	output logic      head_valid,
	output job_t      head_job,
	input  wire logic pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/mtc_back.sv
// mtc_back: plays queued jobs out as characters into the output register, one per cycle
// while out_stall is low; depends on mtc_pkg; pops jobs from mtc_queue
`timescale 1ns / 1ps
`default_nettype none

module mtc_back
	import mtc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_item_t out_item
);

	logic       busy_q;
	job_t       job_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_item_q;

	logic       load;
	logic       emit;
	job_t       cur;
	logic [2:0] idx;
	out_item_t  item_n;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		load = !out_valid_q || !out_stall;
		cur  = busy_q ? job_q : head_job;
		idx  = busy_q ? idx_q : 3'd0;
		emit = load && (busy_q || head_valid);
		pop  = emit && !busy_q;

		item_n = '0;
		if (cur.kind == JOB_DEC) begin
			item_n.char_out    = cur.glyph;
			item_n.last_of_run = 1'b1;
		end else if (idx < cur.len) begin
			item_n.char_out    = cur.pat[idx] ? cfg.dash_char : cfg.dot_char;
			item_n.last_of_run = 1'b0;
		end else begin
			item_n.char_out    = cfg.separator_char;
			item_n.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= item_n;
			job_q      <= cur;
			idx_q      <= idx + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q <= !item_n.last_of_run;
			end
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/morse_text_codec.sv
// morse_text_codec: top level, configuration registers and the front, queue and back parts
// depends on mtc_pkg, mtc_front, mtc_queue and mtc_back
//
// Usage: text characters arrive on the in channel (in_valid, in_stall, in_item) and
// result characters leave on the out channel (out_valid, out_stall, out_item); a request
// moves when valid is high and stall is low. Registers are written through cfg_we,
// cfg_index and cfg_data: direction, dot, dash and separator. The user must write them
// only while the block is idle; the block itself does not enforce this. In encode
// direction a known character gives its code symbols and then the separator, the final
// one flagged last_of_run. In decode direction symbols gather into a token held in the
// front; a separator or end_of_text looks it up and gives one character if known. The
// front takes a request every cycle while the job queue has room; the back writes one
// result per cycle into the output register while out_stall is low, so an encoded
// character gives its code length plus one results (at most eight) and a decoded one
// gives one. When the receiver stalls, the output register holds, the back waits and the
// queue fills; once it is full in_stall rises. Reset empties queue and output, clears the
// token and loads the default configuration; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module morse_text_codec
	import mtc_pkg::*;
#(
	parameter int MAX_SYMBOLS = MTC_MAX_SYMBOLS,
	parameter int QUEUE_DEPTH = MTC_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	job_t push_job;
	logic head_valid;
	job_t head_job;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction      <= DIR_ENCODE;
			cfg_q.dot_char       <= RESET_DOT;
			cfg_q.dash_char      <= RESET_DASH;
			cfg_q.separator_char <= RESET_SEP;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_DIRECTION: cfg_q.direction      <= direction_t'(cfg_data[0]);
				CFG_DOT:       cfg_q.dot_char       <= cfg_data;
				CFG_DASH:      cfg_q.dash_char      <= cfg_data;
				CFG_SEPARATOR: cfg_q.separator_char <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mtc_front #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	mtc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	mtc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire
